// ===== rtl/csl_pkg.sv =====
// Shared types, character codes and symbol/keyword tables for the C subset lexer.
package csl_pkg;

   localparam int WORD_MAX_DEFAULT = 32;
   localparam int CMDQ_DEPTH       = 4;
   localparam int NUM_KEYS         = 9;
   localparam int LEN_W            = 6;
   localparam int LINE_W           = 24;

   localparam logic [LINE_W-1:0] LINE_MAX = '1;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam logic [1:0] REC_HEADER   = 2'd0;
   localparam logic [1:0] REC_TEXT     = 2'd1;
   localparam logic [1:0] REC_END      = 2'd2;
   localparam logic [1:0] REC_OPEN_END = 2'd3;

   localparam logic [5:0] KIND_INT      = 6'd0;
   localparam logic [5:0] KIND_IDENT    = 6'd1;
   localparam logic [5:0] KIND_STRING   = 6'd2;
   localparam logic [5:0] KIND_KEY_BASE = 6'd3;
   localparam logic [5:0] KIND_SYM_BASE = 6'd12;

   localparam logic [0:0] REG_FIRST_LINE = 1'b0;

   localparam logic [63:0] KEY_TEXT [NUM_KEYS] = '{
      "int", "return", "if", "else", "for", "while", "break", "continue", "char"
   };
   localparam logic [3:0] KEY_LEN [NUM_KEYS] = '{
      4'd3, 4'd6, 4'd2, 4'd4, 4'd3, 4'd5, 4'd5, 4'd8, 4'd4
   };

   typedef struct packed {
      logic [7:0] source_byte;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      logic [1:0]        record_type;
      logic [5:0]        token_kind;
      logic [7:0]        text_byte;
      logic [LINE_W-1:0] line_number;
      logic              word_overflow;
      logic              last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_HDR  = 2'd0,
      OP_TEXT = 2'd1,
      OP_END  = 2'd2
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type        op;
      logic [5:0]        kind;
      logic [1:0]        end_type;
      logic              overflow;
      logic [LEN_W-1:0]  len;
      logic [LINE_W-1:0] line;
      logic              last;
   } cmd_type;

   typedef struct packed {
      logic             we;
      logic [LEN_W-1:0] addr;
      logic [7:0]       data;
   } memw_type;

   typedef struct packed {
      logic              we;
      logic [LINE_W-1:0] value;
   } cfg_type;

   function automatic cmd_type mk_cmd(cmd_op_type op, logic [5:0] kind, logic [1:0] et,
                                      logic ovf, logic [LEN_W-1:0] len,
                                      logic [LINE_W-1:0] line);
      cmd_type c;
      c.op       = op;
      c.kind     = kind;
      c.end_type = et;
      c.overflow = ovf;
      c.len      = len;
      c.line     = line;
      c.last     = 1'b0;
      return c;
   endfunction

   // Does byte b equal character pos of keyword k?
   function automatic logic key_match(int unsigned k, logic [LEN_W-1:0] pos, logic [7:0] b);
      logic [LEN_W-1:0] kl;
      logic [LEN_W-1:0] sh;
      kl = LEN_W'(KEY_LEN[k]);
      sh = kl - pos - LEN_W'(1);
      if (pos >= kl) begin
         return 1'b0;
      end
      return KEY_TEXT[k][{sh[2:0], 3'b000} +: 8] == b;
   endfunction

   // Single-character symbol: {valid, index}.
   function automatic logic [6:0] sym_first(logic [7:0] b);
      logic [6:0] r;
      case (b)
         "{": r = {1'b1, 6'd2};
         "}": r = {1'b1, 6'd3};
         "(": r = {1'b1, 6'd4};
         ")": r = {1'b1, 6'd5};
         ";": r = {1'b1, 6'd6};
         "-": r = {1'b1, 6'd7};
         "~": r = {1'b1, 6'd8};
         "!": r = {1'b1, 6'd9};
         "+": r = {1'b1, 6'd10};
         "*": r = {1'b1, 6'd11};
         "/": r = {1'b1, 6'd12};
         "%": r = {1'b1, 6'd13};
         "|": r = {1'b1, 6'd14};
         "&": r = {1'b1, 6'd15};
         "^": r = {1'b1, 6'd16};
         "<": r = {1'b1, 6'd23};
         ">": r = {1'b1, 6'd25};
         "=": r = {1'b1, 6'd27};
         ":": r = {1'b1, 6'd38};
         "?": r = {1'b1, 6'd39};
         ",": r = {1'b1, 6'd40};
         "[": r = {1'b1, 6'd41};
         "]": r = {1'b1, 6'd42};
         default: r = '0;
      endcase
      return r;
   endfunction

   // Longer symbol formed by appending b to symbol k: {valid, index}.
   function automatic logic [6:0] sym_next(logic [5:0] k, logic [7:0] b);
      logic [6:0] r;
      r = '0;
      case (k)
         6'd10: begin
            if (b == "+") r = {1'b1, 6'd0};
            else if (b == "=") r = {1'b1, 6'd28};
         end
         6'd7: begin
            if (b == "-") r = {1'b1, 6'd1};
            else if (b == "=") r = {1'b1, 6'd29};
         end
         6'd11: if (b == "=") r = {1'b1, 6'd30};
         6'd12: if (b == "=") r = {1'b1, 6'd31};
         6'd13: if (b == "=") r = {1'b1, 6'd32};
         6'd14: begin
            if (b == "|") r = {1'b1, 6'd20};
            else if (b == "=") r = {1'b1, 6'd37};
         end
         6'd15: begin
            if (b == "&") r = {1'b1, 6'd19};
            else if (b == "=") r = {1'b1, 6'd35};
         end
         6'd16: if (b == "=") r = {1'b1, 6'd36};
         6'd23: begin
            if (b == "<") r = {1'b1, 6'd17};
            else if (b == "=") r = {1'b1, 6'd24};
         end
         6'd25: begin
            if (b == ">") r = {1'b1, 6'd18};
            else if (b == "=") r = {1'b1, 6'd26};
         end
         6'd27: if (b == "=") r = {1'b1, 6'd21};
         6'd9:  if (b == "=") r = {1'b1, 6'd22};
         6'd17: if (b == "=") r = {1'b1, 6'd33};
         6'd18: if (b == "=") r = {1'b1, 6'd34};
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/csl_front.sv =====
// Front end: classifies each source byte, tracks word/string/symbol state, issues commands.
module csl_front #(
   parameter int WORD_MAX = csl_pkg::WORD_MAX_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  csl_pkg::req_type      req_payload,
   input  csl_pkg::cfg_type      cfg,
   output csl_pkg::memw_type     memw,
   output logic [1:0]            push_count,
   output csl_pkg::cmd_type [1:0] push_cmd,
   input  logic                  q_room,
   input  logic                  text_done,
   output logic                  text_busy
);
   import csl_pkg::*;

   localparam int LW = $clog2(WORD_MAX + 1);

   logic                 in_string_ff, in_string_in;
   logic                 bs_ff, bs_in;
   logic                 pend_v_ff, pend_v_in;
   logic [5:0]           pend_k_ff, pend_k_in;
   logic [LW-1:0]        len_ff, len_in;
   logic                 trunc_ff, trunc_in;
   logic                 digit_ff, digit_in;
   logic [NUM_KEYS-1:0]  kmask_ff, kmask_in;
   logic [LINE_W-1:0]    line_ff, line_in;
   logic                 busy_ff, busy_in;
   logic                 accept;
   cmd_type [1:0]        cmds;
   logic [1:0]           ncmd;
   memw_type             memw_c;

   function automatic cmd_type word_cmd(logic [LEN_W-1:0] len, logic trunc, logic digit,
                                        logic [NUM_KEYS-1:0] kmask, logic [LINE_W-1:0] line);
      logic       found;
      logic [5:0] kk;
      found = 1'b0;
      kk    = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (!found && !trunc && kmask[k] && len == LEN_W'(KEY_LEN[k])) begin
            found = 1'b1;
            kk    = 6'(k);
         end
      end
      if (digit) begin
         return mk_cmd(OP_TEXT, KIND_INT, REC_END, trunc, len, line);
      end else if (found) begin
         return mk_cmd(OP_HDR, KIND_KEY_BASE + kk, REC_HEADER, 1'b0, len, line);
      end
      return mk_cmd(OP_TEXT, KIND_IDENT, REC_END, trunc, len, line);
   endfunction

   assign req_stall  = busy_ff || !q_room;
   assign accept     = req_valid && !req_stall;
   assign text_busy  = busy_ff;
   assign push_count = accept ? ncmd : 2'd0;
   assign push_cmd   = cmds;
   assign memw       = '{we: memw_c.we && accept, addr: memw_c.addr, data: memw_c.data};

   always_comb begin
      logic [7:0] b;
      logic       eos;
      logic       consumed;
      logic       do_append;
      logic       is_ws;
      logic [6:0] s1;
      logic [6:0] sx;
      b         = req_payload.source_byte;
      eos       = req_payload.end_of_source;
      s1        = sym_first(b);
      sx        = sym_next(pend_k_ff, b);
      is_ws     = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
      consumed  = 1'b0;
      do_append = 1'b0;

      in_string_in = in_string_ff;
      pend_v_in    = pend_v_ff;
      pend_k_in    = pend_k_ff;
      len_in       = len_ff;
      trunc_in     = trunc_ff;
      digit_in     = digit_ff;
      kmask_in     = kmask_ff;
      line_in      = line_ff;
      cmds         = '0;
      ncmd         = 2'd0;
      memw_c       = '0;

      if (in_string_ff) begin
         if (b == CH_QUOTE && !bs_ff) begin
            cmds[0]      = mk_cmd(OP_TEXT, KIND_STRING, REC_END, trunc_ff, LEN_W'(len_ff),
                                  line_ff);
            ncmd         = 2'd1;
            len_in       = '0;
            trunc_in     = 1'b0;
            in_string_in = 1'b0;
         end else begin
            do_append = 1'b1;
         end
         consumed = 1'b1;
      end else if (pend_v_ff) begin
         if (sx[6]) begin
            pend_k_in = sx[5:0];
            consumed  = 1'b1;
         end else begin
            cmds[0]   = mk_cmd(OP_HDR, KIND_SYM_BASE + pend_k_ff, REC_HEADER, 1'b0, '0,
                               line_ff);
            ncmd      = 2'd1;
            pend_v_in = 1'b0;
            pend_k_in = '0;
         end
      end

      if (!consumed) begin
         if (b == CH_QUOTE || s1[6] || is_ws) begin
            // A pending symbol and a buffered word never coexist, so one slot suffices.
            if (len_ff != '0) begin
               cmds[ncmd[0]] = word_cmd(LEN_W'(len_ff), trunc_ff, digit_ff, kmask_ff, line_ff);
               ncmd          = ncmd + 2'd1;
               len_in        = '0;
               trunc_in      = 1'b0;
            end
            if (b == CH_QUOTE) begin
               in_string_in = 1'b1;
            end else if (s1[6]) begin
               pend_v_in = 1'b1;
               pend_k_in = s1[5:0];
            end
         end else begin
            do_append = 1'b1;
         end
      end

      if (b == CH_LF && line_ff != LINE_MAX) begin
         line_in = line_ff + LINE_W'(1);
      end

      if (do_append) begin
         if (len_ff < LW'(WORD_MAX)) begin
            memw_c.we   = 1'b1;
            memw_c.addr = LEN_W'(len_ff);
            memw_c.data = b;
            len_in      = len_ff + LW'(1);
            if (len_ff == '0) begin
               digit_in = (b >= CH_ZERO) && (b <= CH_NINE);
            end
            for (int k = 0; k < NUM_KEYS; k++) begin
               kmask_in[k] = (len_ff == '0 || kmask_ff[k]) && key_match(k, LEN_W'(len_ff), b);
            end
         end else begin
            trunc_in = 1'b1;
         end
      end

      if (eos) begin
         if (pend_v_in) begin
            cmds[ncmd[0]] = mk_cmd(OP_HDR, KIND_SYM_BASE + pend_k_in, REC_HEADER, 1'b0, '0,
                                   line_in);
            ncmd          = ncmd + 2'd1;
            pend_v_in     = 1'b0;
            pend_k_in     = '0;
         end
         if (in_string_in) begin
            if (len_in == '0) begin
               cmds[ncmd[0]] = mk_cmd(OP_END, KIND_STRING, REC_OPEN_END, 1'b0, '0, line_in);
            end else begin
               cmds[ncmd[0]] = mk_cmd(OP_TEXT, KIND_STRING, REC_OPEN_END, trunc_in,
                                      LEN_W'(len_in), line_in);
            end
            ncmd         = ncmd + 2'd1;
            in_string_in = 1'b0;
         end else if (len_in != '0) begin
            cmds[ncmd[0]] = word_cmd(LEN_W'(len_in), trunc_in, digit_in, kmask_in, line_in);
            ncmd          = ncmd + 2'd1;
         end
         len_in   = '0;
         trunc_in = 1'b0;
      end

      bs_in = !eos && (b == CH_BSLASH);

      if (ncmd != 2'd0) begin
         cmds[1'(ncmd - 2'd1)].last = 1'b1;
      end

      busy_in = busy_ff;
      if (accept && ((ncmd != 2'd0 && cmds[0].op == OP_TEXT) ||
                     (ncmd == 2'd2 && cmds[1].op == OP_TEXT))) begin
         busy_in = 1'b1;
      end else if (text_done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_string_ff <= 1'b0;
         bs_ff        <= 1'b0;
         pend_v_ff    <= 1'b0;
         pend_k_ff    <= '0;
         len_ff       <= '0;
         trunc_ff     <= 1'b0;
         digit_ff     <= 1'b0;
         kmask_ff     <= '0;
         line_ff      <= LINE_W'(1);
         busy_ff      <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (cfg.we) begin
            line_ff <= cfg.value;
         end else if (accept) begin
            line_ff <= line_in;
         end
         if (accept) begin
            in_string_ff <= in_string_in;
            bs_ff        <= bs_in;
            pend_v_ff    <= pend_v_in;
            pend_k_ff    <= pend_k_in;
            len_ff       <= len_in;
            trunc_ff     <= trunc_in;
            digit_ff     <= digit_in;
            kmask_ff     <= kmask_in;
         end
      end
   end

endmodule

// ===== rtl/csl_cmdq.sv =====
// Command queue between front and back end: up to two pushes and one pop per cycle.
module csl_cmdq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_count,
   input  csl_pkg::cmd_type [1:0] push_cmd,
   input  logic                  pop,
   output csl_pkg::cmd_type      head,
   output logic                  nonempty,
   output logic                  room,
   output logic [$clog2(csl_pkg::CMDQ_DEPTH+1)-1:0] count
);
   import csl_pkg::*;

   localparam int AW = $clog2(CMDQ_DEPTH);
   localparam int CW = $clog2(CMDQ_DEPTH + 1);

   cmd_type         q_ff [CMDQ_DEPTH];
   logic [AW-1:0]   wr_ff, wr_in;
   logic [AW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;

   assign head     = q_ff[rd_ff];
   assign nonempty = count_ff != '0;
   assign room     = count_ff <= CW'(CMDQ_DEPTH - 2);
   assign count    = count_ff;

   always_comb begin
      wr_in    = wr_ff + AW'(push_count);
      rd_in    = pop ? rd_ff + AW'(1) : rd_ff;
      count_in = count_ff + CW'(push_count) - (pop ? CW'(1) : CW'(0));
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         q_ff[wr_ff] <= push_cmd[0];
      end
      if (push_count == 2'd2) begin
         q_ff[wr_ff + AW'(1)] <= push_cmd[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/csl_back.sv =====
// Back end: expands commands into result records, replaying word text from the buffer.
module csl_back #(
   parameter int WORD_MAX = csl_pkg::WORD_MAX_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  csl_pkg::memw_type memw,
   input  csl_pkg::cmd_type  head,
   input  logic              nonempty,
   output logic              pop,
   output logic              text_done,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output csl_pkg::rsp_type  rsp_payload
);
   import csl_pkg::*;

   localparam int AW = $clog2(WORD_MAX);

   typedef enum logic [4:0] {
      B_IDLE  = 5'b00001,
      B_HEAD  = 5'b00010,
      B_FETCH = 5'b00100,
      B_BYTE  = 5'b01000,
      B_TAIL  = 5'b10000
   } back_state_type;

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [AW-1:0]  idx_ff, idx_in;
   logic [7:0]     word_mem [WORD_MAX];
   logic [7:0]     rd_data_ff;
   logic           out_valid_ff, out_valid_in;
   rsp_type        out_ff, out_in;
   logic           load;
   logic           emit;

   assign load        = !out_valid_ff || !rsp_stall;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   always_ff @(posedge clock) begin
      if (memw.we) begin
         word_mem[memw.addr[AW-1:0]] <= memw.data;
      end
      rd_data_ff <= word_mem[idx_ff];
   end

   always_comb begin
      logic last_byte;
      last_byte = (LEN_W'(idx_ff) + LEN_W'(1)) == cmd_ff.len;
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      idx_in    = idx_ff;
      pop       = 1'b0;
      text_done = 1'b0;
      emit      = 1'b0;
      out_in    = '{record_type: REC_HEADER, token_kind: cmd_ff.kind, text_byte: 8'd0,
                    line_number: cmd_ff.line, word_overflow: 1'b0, last: 1'b0};
      case (state_ff)
         B_IDLE: begin
            if (nonempty) begin
               pop      = 1'b1;
               cmd_in   = head;
               state_in = B_HEAD;
            end
         end
         B_HEAD: begin
            if (load) begin
               emit = 1'b1;
               case (cmd_ff.op)
                  OP_TEXT: begin
                     idx_in   = '0;
                     state_in = (cmd_ff.len == '0) ? B_TAIL : B_FETCH;
                  end
                  OP_END: begin
                     out_in.record_type = cmd_ff.end_type;
                     out_in.last        = cmd_ff.last;
                     state_in           = B_IDLE;
                  end
                  default: begin
                     out_in.last = cmd_ff.last;
                     state_in    = B_IDLE;
                  end
               endcase
            end
         end
         B_FETCH: begin
            // The buffer read is registered; data for idx is ready next cycle.
            state_in = B_BYTE;
         end
         B_BYTE: begin
            if (load) begin
               emit               = 1'b1;
               out_in.record_type = REC_TEXT;
               out_in.text_byte   = rd_data_ff;
               if (last_byte) begin
                  state_in = B_TAIL;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = B_FETCH;
               end
            end
         end
         B_TAIL: begin
            if (load) begin
               emit                 = 1'b1;
               text_done            = 1'b1;
               out_in.record_type   = cmd_ff.end_type;
               out_in.word_overflow = cmd_ff.overflow;
               out_in.last          = cmd_ff.last;
               state_in             = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
      out_valid_in = emit ? 1'b1 : (load ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      if (emit) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== rtl/c_subset_lexer.sv =====
// Streaming C subset lexer: top level with register port, front end, command queue and back end.
// The lexer takes one source byte per cycle and emits token records: a header per token, and
// for integers, identifiers and strings the text as one record per byte closed by an end record.
// A byte is taken in the cycle it arrives unless the command queue lacks two free entries or a
// word or string is still being replayed from the word buffer; a byte that ends an integer,
// identifier or string therefore holds off the next byte until that token's end record has
// entered the output register. Header-only tokens (symbols, keywords) pass through the back-end
// states B_IDLE and B_HEAD, and every text byte passes through B_FETCH and B_BYTE, as the word
// buffer read is registered. first_line_number sits at byte address 0 and also loads the running
// line counter when written; write it only while the lexer is idle.
module c_subset_lexer #(
   parameter int WORD_MAX = csl_pkg::WORD_MAX_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  csl_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output csl_pkg::rsp_type rsp_payload,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import csl_pkg::*;

   localparam int QCW = $clog2(CMDQ_DEPTH + 1);

   logic [LINE_W-1:0] first_line_ff;
   cfg_type           cfg;
   memw_type          memw;
   logic [1:0]        push_count;
   cmd_type [1:0]     push_cmd;
   cmd_type           head;
   logic              q_room;
   logic              q_nonempty;
   logic [QCW-1:0]    q_count;
   logic              pop;
   logic              text_done;
   logic              text_busy;

   assign csr_pready = 1'b1;
   assign cfg.we     = csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_FIRST_LINE;
   assign cfg.value  = csr_pwdata[LINE_W-1:0];
   assign csr_prdata = (csr_paddr[2] == REG_FIRST_LINE) ? {8'd0, first_line_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_line_ff <= LINE_W'(1);
      end else if (cfg.we) begin
         first_line_ff <= cfg.value;
      end
   end

   csl_front #(.WORD_MAX(WORD_MAX)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cfg         (cfg),
      .memw        (memw),
      .push_count  (push_count),
      .push_cmd    (push_cmd),
      .q_room      (q_room),
      .text_done   (text_done),
      .text_busy   (text_busy)
   );

   csl_cmdq u_cmdq (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head       (head),
      .nonempty   (q_nonempty),
      .room       (q_room),
      .count      (q_count)
   );

   csl_back #(.WORD_MAX(WORD_MAX)) u_back (
      .clock       (clock),
      .reset       (reset),
      .memw        (memw),
      .head        (head),
      .nonempty    (q_nonempty),
      .pop         (pop),
      .text_done   (text_done),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      q_count <= QCW'(CMDQ_DEPTH))
      else $error("command queue overfilled");

   a_text_while_busy : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.record_type == REC_TEXT) |-> text_busy)
      else $error("text record shown while word buffer is unlocked");

   a_text_not_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.record_type == REC_TEXT) |-> !rsp_payload.last)
      else $error("text byte record flagged as last");

   a_busy_from_accept : assert property (@(posedge clock) disable iff (reset)
      $rose(text_busy) |-> $past(req_valid && !req_stall))
      else $error("word buffer locked without an accepted byte");
`endif

endmodule
